>>> design/mari_pkg.sv
// package for the mass/age/radius interpolator
// word types, command and status codes; no dependencies
`timescale 1ns / 1ps

package mari_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MASS_ERR = 2'd1,
        ST_AGE_ERR  = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] mass;
        logic [31:0] age;
        logic [31:0] radius_in;
    } t_in_word;

    typedef struct packed {
        logic [31:0] radius_out;
        logic [1:0]  status;
    } t_out_word;

endpackage

>>> design/mari_div.sv
// iterative restoring divider, 64-bit dividend by 33-bit divisor, one bit a cycle
// depends on nothing; quotient saturates to 32 bits
`timescale 1ns / 1ps

module mari_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quo
);
    logic [63:0] r_quo;
    logic [32:0] r_rem;
    logic [63:0] r_num;
    logic [32:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [33:0] w_shift;
    logic [34:0] w_diff;

    assign w_shift = {r_rem, r_num[63]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            o_done <= 1'b0;
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quo  <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[62:0], 1'b0};
            // remainder stays below the divisor, so 33 bits hold it
            if (!w_diff[34]) begin
                r_rem <= w_diff[32:0];
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= w_shift[32:0];
                r_quo <= {r_quo[62:0], 1'b0};
            end
            r_cnt  <= r_cnt + 7'd1;
            r_busy <= (r_cnt != 7'd63);
            o_done <= (r_cnt == 7'd63);
        end else begin
            o_done <= 1'b0;
        end
    end

    assign o_quo = (|r_quo[63:32]) ? 32'hFFFF_FFFF : r_quo[31:0];
endmodule

>>> design/mass_age_radius_interpolator.sv
// top level of the mass/age/radius interpolator: row memory, sequencer
// depends on mari_pkg and mari_div
// clear/append: result passes S_DEC and S_OUT before o_valid, next word taken after the result
// query: mass walk and each block's age scan visit each row in a read state, then a compare state,
// then six 33-bit multiplies and three divisions on the shared divider
// ready low while a word is in work; reset empties the table, memory unset
`timescale 1ns / 1ps

module mass_age_radius_interpolator #(
    parameter int TABLE_ROWS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  mari_pkg::t_in_word   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output mari_pkg::t_out_word  o_data
);
    import mari_pkg::*;

    localparam int AW = $clog2(TABLE_ROWS);
    localparam int CW = $clog2(TABLE_ROWS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_MRD, S_MCHK, S_A1RD, S_A1CHK,
        S_B1, S_B1M, S_B1D, S_FM, S_FD, S_OUT
    } t_state;

    t_state      r_state;
    logic [95:0] r_mem [TABLE_ROWS];
    logic [95:0] r_rd;
    logic [AW-1:0] r_addr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_i;
    t_in_word    r_in;
    logic [31:0] r_ml, r_mu, r_bm;
    logic [CW-1:0] r_lo_start, r_hi_start, r_j, r_blk_start;
    logic        r_first;
    logic        r_second;
    logic [31:0] r_al, r_rl, r_au, r_ru;
    logic [31:0] r_r1;
    logic [32:0] r_ma, r_mb;
    logic [31:0] r_mx, r_my;
    logic [63:0] r_pa, r_pb;
    logic        r_mul_ph;
    logic        r_div_go;
    logic [63:0] r_div_num;
    logic [32:0] r_div_den;
    logic [31:0] r_rad;
    t_status     r_status;
    logic        w_div_done;
    logic [31:0] w_div_quo;
    logic [31:0] w_rm, w_ra, w_rr;
    logic [63:0] w_prod;

    assign w_rm = r_rd[95:64];
    assign w_ra = r_rd[63:32];
    assign w_rr = r_rd[31:0];
    // one shared 33x32 multiplier
    assign w_prod = r_mul_ph ? ({31'd0, r_mb} * {32'd0, r_my})
                             : ({31'd0, r_ma} * {32'd0, r_mx});

    assign o_data = '{radius_out: r_rad, status: r_status};

    mari_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_addr];
        if (r_state == S_DEC && r_in.command == CMD_APPEND && r_count < CW'(TABLE_ROWS))
            r_mem[r_count[AW-1:0]] <= {r_in.mass, r_in.age, r_in.radius_in};
    end

    assign o_ready = (r_state == S_IDLE) && !o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            o_valid  <= 1'b0;
            r_div_go <= 1'b0;
            r_mul_ph <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_valid) begin
                        if (i_ready) o_valid <= 1'b0;
                    end else if (i_valid) begin
                        r_in    <= i_data;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_rad <= 32'd0;
                    case (r_in.command)
                        CMD_CLEAR: begin
                            r_count  <= '0;
                            r_status <= ST_OK;
                            r_state  <= S_OUT;
                        end
                        CMD_APPEND: begin
                            if (r_count < CW'(TABLE_ROWS)) begin
                                r_count  <= r_count + CW'(1);
                                r_status <= ST_OK;
                            end else begin
                                r_status <= ST_FULL;
                            end
                            r_state <= S_OUT;
                        end
                        CMD_QUERY: begin
                            if (r_count == '0) begin
                                r_status <= ST_MASS_ERR;
                                r_state  <= S_OUT;
                            end else begin
                                r_status   <= ST_OK;
                                r_i        <= '0;
                                r_addr     <= '0;
                                r_lo_start <= '0;
                                r_first    <= 1'b1;
                                r_state    <= S_MRD;
                            end
                        end
                        default: begin
                            r_status <= ST_OK;
                            r_state  <= S_OUT;
                        end
                    endcase
                end
                S_MRD: r_state <= S_MCHK;
                S_MCHK: begin
                    if (r_first) r_ml <= w_rm;
                    if (w_rm <= r_in.mass) begin
                        r_first <= 1'b0;
                        if (!r_first && w_rm > r_ml) begin
                            r_lo_start <= r_i;
                            r_ml       <= w_rm;
                        end
                        if (r_i + CW'(1) >= r_count) begin
                            r_status <= ST_MASS_ERR;
                            r_state  <= S_OUT;
                        end else begin
                            r_i     <= r_i + CW'(1);
                            r_addr  <= AW'(r_i + CW'(1));
                            r_state <= S_MRD;
                        end
                    end else if (r_i == '0) begin
                        r_status <= ST_MASS_ERR;
                        r_state  <= S_OUT;
                    end else begin
                        r_hi_start  <= r_i;
                        r_mu        <= w_rm;
                        r_second    <= 1'b0;
                        r_blk_start <= r_lo_start;
                        r_j         <= r_lo_start;
                        r_addr      <= AW'(r_lo_start);
                        r_first     <= 1'b1;
                        r_state     <= S_A1RD;
                    end
                end
                S_A1RD: r_state <= S_A1CHK;
                S_A1CHK: begin
                    if (r_first) r_bm <= w_rm;
                    r_first <= 1'b0;
                    if ((r_first || w_rm == r_bm) && w_ra <= r_in.age) begin
                        r_al <= w_ra;
                        r_rl <= w_rr;
                        if (r_j + CW'(1) >= r_count) begin
                            r_status <= ST_AGE_ERR;
                            r_state  <= S_OUT;
                        end else begin
                            r_j     <= r_j + CW'(1);
                            r_addr  <= AW'(r_j + CW'(1));
                            r_state <= S_A1RD;
                        end
                    end else if (r_j == r_blk_start || (!r_first && w_rm != r_bm)) begin
                        r_status <= ST_AGE_ERR;
                        r_state  <= S_OUT;
                    end else begin
                        r_au    <= w_ra;
                        r_ru    <= w_rr;
                        r_state <= S_B1;
                    end
                end
                S_B1: begin
                    r_ma     <= {1'b0, r_au - r_in.age};
                    r_mx     <= r_rl;
                    r_mb     <= {1'b0, r_in.age - r_al};
                    r_my     <= r_ru;
                    r_mul_ph <= 1'b0;
                    r_state  <= S_B1M;
                end
                S_B1M: begin
                    if (!r_mul_ph) begin
                        r_pa <= w_prod;
                        r_mul_ph <= 1'b1;
                    end else begin
                        r_div_num <= r_pa + w_prod;
                        r_div_den <= {1'b0, r_au - r_al};
                        r_div_go  <= 1'b1;
                        r_mul_ph  <= 1'b0;
                        r_state   <= S_B1D;
                    end
                end
                S_B1D: begin
                    r_div_go <= 1'b0;
                    if (w_div_done) begin
                        if (!r_second) begin
                            r_r1        <= w_div_quo;
                            r_second    <= 1'b1;
                            r_blk_start <= r_hi_start;
                            r_j         <= r_hi_start;
                            r_addr      <= AW'(r_hi_start);
                            r_first     <= 1'b1;
                            r_state     <= S_A1RD;
                        end else begin
                            r_ma    <= {1'b0, r_mu - r_in.mass};
                            r_mx    <= r_r1;
                            r_mb    <= {1'b0, r_in.mass - r_ml};
                            r_my    <= w_div_quo;
                            r_state <= S_FM;
                        end
                    end
                end
                S_FM: begin
                    if (!r_mul_ph) begin
                        r_pb <= w_prod;
                        r_mul_ph <= 1'b1;
                    end else begin
                        r_div_num <= r_pb + w_prod;
                        r_div_den <= {1'b0, r_mu - r_ml};
                        r_div_go  <= 1'b1;
                        r_mul_ph  <= 1'b0;
                        r_state   <= S_FD;
                    end
                end
                S_FD: begin
                    r_div_go <= 1'b0;
                    if (w_div_done) begin
                        r_rad   <= w_div_quo;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ROWS)) else $error("row count overflow");
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status != ST_OK) |-> (o_data.radius_out == 32'd0))
        else $error("error word with radius");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> !o_valid) else $error("duplicate word");
endmodule

>>> bench/mari_checker.sv
// checker for the mass/age/radius interpolator: watches both word channels,
// predicts each result from its own copy of the row table; depends on mari_pkg
`timescale 1ns / 1ps

module mari_checker #(
    parameter int TABLE_ROWS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  mari_pkg::t_in_word   i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  mari_pkg::t_out_word  i_out_word,
    output int                   o_fail_count,
    output int                   o_pending
);
    import mari_pkg::*;

    logic [31:0] row_mass [TABLE_ROWS];
    logic [31:0] row_age  [TABLE_ROWS];
    logic [31:0] row_rad  [TABLE_ROWS];
    int unsigned n_rows;
    t_out_word   radius_due [$];
    int          n_mismatch;

    // scan one mass block for the two rows around the query age
    function automatic bit bracket_age(input int unsigned start, input logic [31:0] qa,
                                       output int unsigned upper);
        int unsigned j;
        j = start;
        upper = 0;
        while (j < n_rows && row_mass[j] == row_mass[start] && row_age[j] <= qa)
            j++;
        if (j == start || j >= n_rows || row_mass[j] != row_mass[start])
            return 1'b0;
        upper = j;
        return 1'b1;
    endfunction

    function automatic logic [63:0] age_interp(input int unsigned hi, input logic [31:0] qa);
        logic [63:0] al, au, num;
        al = {32'd0, row_age[hi-1]};
        au = {32'd0, row_age[hi]};
        num = (au - {32'd0, qa}) * {32'd0, row_rad[hi-1]}
            + ({32'd0, qa} - al) * {32'd0, row_rad[hi]};
        return num / (au - al);
    endfunction

    function automatic t_out_word radius_predict(input t_in_word w);
        t_out_word   r;
        int unsigned i, lo_start, up1, up2;
        logic [31:0] ml, mu;
        logic [63:0] r1, r2, num, res;
        r = '0;
        case (t_cmd'(w.command))
            CMD_CLEAR: n_rows = 0;
            CMD_APPEND: begin
                if (n_rows >= TABLE_ROWS) begin
                    r.status = ST_FULL;
                end else begin
                    row_mass[n_rows] = w.mass;
                    row_age[n_rows]  = w.age;
                    row_rad[n_rows]  = w.radius_in;
                    n_rows++;
                end
            end
            CMD_QUERY: begin
                i = 0;
                lo_start = 0;
                ml = (n_rows == 0) ? 32'd0 : row_mass[0];
                while (i < n_rows && row_mass[i] <= w.mass) begin
                    if (row_mass[i] > ml) begin
                        lo_start = i;
                        ml = row_mass[i];
                    end
                    i++;
                end
                if (n_rows == 0 || i == 0 || i >= n_rows) begin
                    r.status = ST_MASS_ERR;
                end else begin
                    mu = row_mass[i];
                    if (!bracket_age(lo_start, w.age, up1) || !bracket_age(i, w.age, up2)) begin
                        r.status = ST_AGE_ERR;
                    end else begin
                        r1 = age_interp(up1, w.age);
                        r2 = age_interp(up2, w.age);
                        num = ({32'd0, mu} - {32'd0, w.mass}) * r1
                            + ({32'd0, w.mass} - {32'd0, ml}) * r2;
                        res = num / ({32'd0, mu} - {32'd0, ml});
                        r.radius_out = (res > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : res[31:0];
                        r.status = ST_OK;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            n_rows = 0;
            radius_due.delete();
            o_fail_count = 0;
            n_mismatch = 0;
        end else begin
            if (i_in_valid && i_in_ready)
                radius_due.insert(radius_due.size(), radius_predict(i_in_word));
            if (i_out_valid && i_out_ready) begin
                if (radius_due.size() == 0) begin
                    o_fail_count++;
                    if (n_mismatch++ < 10)
                        $display("unexpected result word %h", i_out_word);
                end else begin
                    want = radius_due.pop_front();
                    if (want.radius_out !== i_out_word.radius_out) begin
                        o_fail_count++;
                        if (n_mismatch++ < 10)
                            $display("radius: expected %h got %h", want.radius_out,
                                     i_out_word.radius_out);
                    end
                    if (want.status !== i_out_word.status) begin
                        o_fail_count++;
                        if (n_mismatch++ < 10)
                            $display("status: expected %0d got %0d", want.status,
                                     i_out_word.status);
                    end
                end
            end
        end
        o_pending = radius_due.size();
    end

endmodule

>>> bench/mass_age_radius_interpolator_tb.sv
// testbench top for the mass/age/radius interpolator: makes stimulus and
// gives the verdict; depends on mari_pkg, mari_checker and the design
`timescale 1ns / 1ps

module mass_age_radius_interpolator_tb;
    import mari_pkg::*;

    logic      i_clk, i_rst_n;
    logic      in_valid, in_ready, out_valid, out_ready, in_fire_q;
    t_in_word  in_word;
    t_out_word out_word;
    int        n_fail, n_pending;
    int        words_sent, send_idle_pct, recv_idle_pct;
    bit        hold_req;
    logic [31:0] sorted_vals [8];

    mass_age_radius_interpolator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_data(in_word),
        .o_valid(out_valid), .i_ready(out_ready), .o_data(out_word)
    );

    mari_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_word(in_word),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_word(out_word),
        .o_fail_count(n_fail), .o_pending(n_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("simulation failed");
        $finish;
    end

    always @(posedge i_clk)
        in_fire_q <= in_valid && in_ready;

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_req = 1'b0;
            end
            out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_word(input t_cmd c, input logic [31:0] m, input logic [31:0] a,
                             input logic [31:0] r);
        if (words_sent < 180) begin
            send_idle_pct = 9;
            recv_idle_pct = 75;
        end else if (words_sent < 360) begin
            send_idle_pct = 75;
            recv_idle_pct = 9;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct)
            @(negedge i_clk);
        in_word = '{command: c, mass: m, age: a, radius_in: r};
        in_valid = 1'b1;
        do @(negedge i_clk); while (!in_fire_q);
        in_valid = 1'b0;
        words_sent++;
    endtask

    // n distinct ascending values in [lo, hi]
    task automatic make_sorted(input int n, input logic [31:0] lo, input logic [31:0] hi);
        logic [31:0] v;
        int k, j;
        bit dup;
        k = 0;
        while (k < n) begin
            v = $urandom_range(hi, lo);
            dup = 1'b0;
            for (j = 0; j < k; j++)
                if (sorted_vals[j] == v) dup = 1'b1;
            if (!dup) begin
                j = k;
                while (j > 0 && sorted_vals[j-1] > v) begin
                    sorted_vals[j] = sorted_vals[j-1];
                    j--;
                end
                sorted_vals[j] = v;
                k++;
            end
        end
    endtask

    // clear, load a sorted table, then query it
    task automatic table_session(input int n_queries);
        logic [31:0] blk_mass [6];
        logic [31:0] lo, hi, m_lo, m_hi, a_lo, a_hi, qm, qa;
        int nblk, nage, b, k;
        nblk = $urandom_range(5, 2);
        if ($urandom_range(1)) begin
            lo = $urandom_range(32'hFFFF_0000);
            hi = lo + 32'h0000_FFFF;
        end else begin
            lo = 0;
            hi = 32'hFFFF_FFFF;
        end
        make_sorted(nblk, lo, hi);
        for (b = 0; b < nblk; b++)
            blk_mass[b] = sorted_vals[b];
        m_lo = blk_mass[0];
        m_hi = blk_mass[nblk-1];
        a_lo = 32'hFFFF_FFFF;
        a_hi = 0;
        send_word(CMD_CLEAR, $urandom, $urandom, $urandom);
        for (b = 0; b < nblk; b++) begin
            nage = $urandom_range(5, 2);
            make_sorted(nage, $urandom_range(32'h0010_0000), $urandom_range(32'hFFFF_FFFF,
                        32'hFFF0_0000));
            if (sorted_vals[0] < a_lo) a_lo = sorted_vals[0];
            if (sorted_vals[nage-1] > a_hi) a_hi = sorted_vals[nage-1];
            for (k = 0; k < nage; k++)
                send_word(CMD_APPEND, blk_mass[b], sorted_vals[k], $urandom);
        end
        for (k = 0; k < n_queries; k++) begin
            qm = $urandom_range(m_hi, m_lo);
            qa = $urandom_range(a_hi, a_lo);
            if ($urandom_range(9) == 0) qm = $urandom;
            if ($urandom_range(9) == 0) qa = $urandom;
            send_word(CMD_QUERY, qm, qa, $urandom);
        end
    endtask

    initial begin
        int k;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        hold_req = 1'b0;
        words_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty table, small table, extreme values
        send_word(CMD_QUERY, 32'h0001_0000, 32'h0001_0000, '1);
        send_word(CMD_APPEND, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
        send_word(CMD_APPEND, 32'h0001_0000, 32'h000A_0000, 32'h0003_0000);
        send_word(CMD_APPEND, 32'h0002_0000, 32'h0000_0000, 32'h0002_0000);
        send_word(CMD_APPEND, 32'h0002_0000, 32'h000A_0000, 32'h0006_0000);
        send_word(CMD_QUERY, 32'h0001_8000, 32'h0005_0000, 0);
        send_word(CMD_QUERY, 32'h0001_0000, 32'h0000_0000, 0);
        send_word(CMD_QUERY, 32'h0000_8000, 32'h0005_0000, 0);
        send_word(CMD_QUERY, 32'h0002_0000, 32'h0005_0000, 0);
        send_word(CMD_QUERY, 32'h0001_8000, 32'h000A_0000, 0);
        send_word(CMD_NONE, '1, '1, '1);
        send_word(CMD_QUERY, 32'h0001_8000, 32'h0009_FFFF, 0);
        send_word(CMD_CLEAR, 0, 0, 0);
        send_word(CMD_QUERY, 32'h0001_8000, 32'h0005_0000, 0);
        send_word(CMD_APPEND, 0, 0, '1);
        send_word(CMD_APPEND, 0, '1, 0);
        send_word(CMD_APPEND, '1, 0, '1);
        send_word(CMD_APPEND, '1, '1, '1);
        send_word(CMD_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_word(CMD_QUERY, 0, 0, 0);
        send_word(CMD_QUERY, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 0);
        send_word(CMD_QUERY, '1, '1, 0);

        // receiver holds off as a table session starts, so its appends wait on ready
        hold_req = 1'b1;
        table_session(4);

        while (words_sent < 540) begin
            if ($urandom_range(9) == 0) begin
                for (k = 0; k < 6; k++)
                    send_word(t_cmd'($urandom_range(3)), $urandom, $urandom, $urandom);
            end else begin
                table_session($urandom_range(10, 4));
            end
        end

        while (n_pending != 0)
            @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (n_fail == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
